[design/lpps_pkg.sv]
// ----------------------------------------------------------------------------
// LED pulse pattern sequencer package
// Item kinds, pattern codes, the step and color tables and the color scaler.
// ----------------------------------------------------------------------------
package lpps_pkg;

  // Width of a step index. Tables are padded to a full power of two.
  localparam int StepIdxW = 3;
  localparam int StepSlots = 2 ** StepIdxW;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindPlay  = 2'd1,
    KindStop  = 2'd2,
    KindSolid = 2'd3
  } kind_e;

  localparam logic [2:0] PatNone = 3'd0;

  typedef logic [7:0] chan_t;
  typedef chan_t [2:0] rgb_t;  // index 0 red, 1 green, 2 blue

  localparam logic [StepIdxW-1:0] StepCount [8] = '{
    3'd0, 3'd2, 3'd4, 3'd2, 3'd6, 3'd2, 3'd3, 3'd6
  };

  localparam logic [7:0] StepLevel [8][StepSlots] = '{
    '{8'd0,   8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd70,  8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd220, 8'd0, 8'd220, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd180, 8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0},
    '{8'd140, 8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd120, 8'd0, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd90,  8'd0, 8'd130, 8'd0, 8'd170, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [7:0] StepTicks [8][StepSlots] = '{
    '{8'd0,   8'd0,  8'd0,   8'd0,  8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd100, 8'd24, 8'd0,   8'd0,  8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd100, 8'd80, 8'd100, 8'd60, 8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd40,  8'd20, 8'd0,   8'd0,  8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd80,  8'd50, 8'd80,  8'd50, 8'd80,  8'd150, 8'd0, 8'd0},
    '{8'd50,  8'd20, 8'd0,   8'd0,  8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd20,  8'd24, 8'd16,  8'd0,  8'd0,   8'd0,   8'd0, 8'd0},
    '{8'd65,  8'd28, 8'd70,  8'd34, 8'd95,  8'd28,  8'd0, 8'd0}
  };

  localparam rgb_t Hue [8] = '{
    '{8'd0,   8'd0,   8'd0},
    '{8'd40,  8'd140, 8'd255},
    '{8'd80,  8'd255, 8'd60},
    '{8'd80,  8'd180, 8'd255},
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd120, 8'd40},
    '{8'd255, 8'd255, 8'd255},
    '{8'd170, 8'd255, 8'd90}
  };

  // floor(base * level / 255). For products below 65536,
  // (p + (p >> 8) + 1) >> 8 gives the exact quotient.
  function automatic chan_t scale_chan(chan_t base, logic [7:0] level);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = base * level;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

[design/lpps_in_if.sv]
// ----------------------------------------------------------------------------
// LED pulse pattern sequencer input channel
// Valid/ready channel carrying one command or tick item.
// ----------------------------------------------------------------------------
interface lpps_in_if;
  logic               valid;
  logic               ready;
  lpps_pkg::kind_e    kind;
  logic [2:0]         pattern;
  logic               use_default_color;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;

  modport source (output valid, kind, pattern, use_default_color, red_in, green_in,
                  blue_in, input ready);
  modport sink (input valid, kind, pattern, use_default_color, red_in, green_in,
                blue_in, output ready);
endinterface

[design/lpps_out_if.sv]
// ----------------------------------------------------------------------------
// LED pulse pattern sequencer output channel
// Valid/ready channel carrying the LED color and running flag.
// ----------------------------------------------------------------------------
interface lpps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic       running;

  modport source (output valid, led_red, led_green, led_blue, running, input ready);
  modport sink (input valid, led_red, led_green, led_blue, running, output ready);
endinterface

[design/led_pulse_pattern_sequencer_top.sv]
// ----------------------------------------------------------------------------
// LED pulse pattern sequencer
// Plays fixed RGB pulse patterns driven by millisecond ticks and commands.
// ----------------------------------------------------------------------------
// Usage: every item on the input channel (a tick, a play, a stop or a solid
// color command) produces exactly one transfer on the output channel, giving
// the LED color shown after that item and whether a pattern is still running.
// The sequencer state doubles as the output register, so the result of an
// item is presented in the cycle after its transfer is accepted.
// Throughput is one item per cycle while the receiver keeps up: all table
// lookups, the tick compare and the three 8x8 color scalers sit between the
// state registers and their next values. A new item is taken whenever the
// output is empty or is being taken in the same cycle.
// When the receiver stalls, the result holds and input ready drops until the
// pending result is transferred, so no result is lost or repeated.
// Reset clears all state: nothing playing, base color and LED off, output
// channel empty.
// ----------------------------------------------------------------------------
module led_pulse_pattern_sequencer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpps_in_if.sink        in_i,
  lpps_out_if.source     out_o
);

  localparam int IdxW = lpps_pkg::StepIdxW;

  logic                 playing_q, playing_d;
  logic [IdxW-1:0]      step_idx_q, step_idx_d;
  logic [IdxW-1:0]      step_total_q, step_total_d;
  logic [2:0]           pattern_q, pattern_d;
  logic [7:0]           elapsed_q, elapsed_d;
  lpps_pkg::rgb_t       base_q, base_d;
  lpps_pkg::rgb_t       shown_q, shown_d;
  logic                 out_valid_q;

  logic                 accept_in;
  logic                 scale_en;
  lpps_pkg::rgb_t       scale_base;
  logic [7:0]           scale_level;
  lpps_pkg::rgb_t       in_rgb;
  logic [7:0]           elapsed_inc;
  logic [IdxW-1:0]      next_idx;

  // An item is taken when the output slot is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept_in  = in_i.valid && in_i.ready;

  assign in_rgb      = '{in_i.blue_in, in_i.green_in, in_i.red_in};
  assign elapsed_inc = (elapsed_q == 8'hFF) ? elapsed_q : elapsed_q + 8'd1;
  assign next_idx    = step_idx_q + 1'b1;

  always_comb begin
    playing_d    = playing_q;
    step_idx_d   = step_idx_q;
    step_total_d = step_total_q;
    pattern_d    = pattern_q;
    elapsed_d    = elapsed_q;
    base_d       = base_q;
    shown_d      = shown_q;
    scale_en     = 1'b0;
    scale_base   = base_q;
    scale_level  = '0;

    unique case (in_i.kind)
      lpps_pkg::KindTick: begin
        if (playing_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= lpps_pkg::StepTicks[pattern_q][step_idx_q]) begin
            step_idx_d = next_idx;
            if (next_idx >= step_total_q) begin
              // Last step has run out: turn the LED off.
              playing_d    = 1'b0;
              step_idx_d   = '0;
              step_total_d = '0;
              shown_d      = '0;
            end else begin
              elapsed_d   = '0;
              scale_en    = 1'b1;
              scale_level = lpps_pkg::StepLevel[pattern_q][next_idx];
            end
          end
        end
      end
      lpps_pkg::KindPlay: begin
        if (in_i.pattern == lpps_pkg::PatNone) begin
          playing_d    = 1'b0;
          step_idx_d   = '0;
          step_total_d = '0;
          shown_d      = '0;
        end else begin
          base_d       = in_i.use_default_color ? lpps_pkg::Hue[in_i.pattern] : in_rgb;
          pattern_d    = in_i.pattern;
          step_total_d = lpps_pkg::StepCount[in_i.pattern];
          step_idx_d   = '0;
          elapsed_d    = '0;
          playing_d    = (lpps_pkg::StepCount[in_i.pattern] != '0);
          if (lpps_pkg::StepCount[in_i.pattern] != '0) begin
            scale_en    = 1'b1;
            scale_base  = base_d;
            scale_level = lpps_pkg::StepLevel[in_i.pattern][0];
          end
        end
      end
      lpps_pkg::KindStop: begin
        playing_d    = 1'b0;
        step_idx_d   = '0;
        step_total_d = '0;
        shown_d      = '0;
      end
      lpps_pkg::KindSolid: begin
        // Full intensity shows the given color unchanged; step index is kept.
        playing_d    = 1'b0;
        step_total_d = '0;
        base_d       = in_rgb;
        shown_d      = in_rgb;
      end
      default: begin
        shown_d = shown_q;
      end
    endcase

    if (scale_en) begin
      for (int c = 0; c < 3; c++) begin
        shown_d[c] = lpps_pkg::scale_chan(scale_base[c], scale_level);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q    <= 1'b0;
      step_idx_q   <= '0;
      step_total_q <= '0;
      pattern_q    <= lpps_pkg::PatNone;
      elapsed_q    <= '0;
      base_q       <= '0;
      shown_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept_in) begin
        playing_q    <= playing_d;
        step_idx_q   <= step_idx_d;
        step_total_q <= step_total_d;
        pattern_q    <= pattern_d;
        elapsed_q    <= elapsed_d;
        base_q       <= base_d;
        shown_q      <= shown_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // The state registers hold the result of the last accepted item.
  assign out_o.valid     = out_valid_q;
  assign out_o.led_red   = shown_q[0];
  assign out_o.led_green = shown_q[1];
  assign out_o.led_blue  = shown_q[2];
  assign out_o.running   = playing_q;

endmodule

[verif/led_pulse_pattern_sequencer_top_tb.sv]
// ----------------------------------------------------------------------------
// LED pulse pattern sequencer testbench
// Drives tick, play, stop and solid color commands into the sequencer and
// checks every LED result against a cycle-free behavioral model of the
// pattern player. Directed tests cover idle commands, color extremes, every
// pattern and interrupted playback. Random playback then runs under four
// flow-control phases: no idling, a mostly idle sender, a mostly stalling
// receiver, and light idling on both sides.
// ----------------------------------------------------------------------------
module led_pulse_pattern_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A run stops as failed when this many cycles pass without any transfer.
  localparam int unsigned WatchdogLimit = 2000;
  // Longest sender gap in cycles, so one unlucky draw cannot hang the run.
  localparam int unsigned MaxGap = 30;

  // Pattern tables of the behavioral model: step count, intensity and
  // duration of each step, and the built-in color (red, green, blue).
  localparam int unsigned SeqLen [8] = '{0, 2, 4, 2, 6, 2, 3, 6};
  localparam int unsigned SeqLevel [8][6] = '{
    '{0,   0,   0,   0, 0,   0},
    '{70,  0,   0,   0, 0,   0},
    '{220, 0,   220, 0, 0,   0},
    '{180, 0,   0,   0, 0,   0},
    '{255, 0,   255, 0, 255, 0},
    '{140, 0,   0,   0, 0,   0},
    '{255, 120, 0,   0, 0,   0},
    '{90,  0,   130, 0, 170, 0}
  };
  localparam int unsigned SeqDur [8][6] = '{
    '{0,   0,  0,   0,  0,  0},
    '{100, 24, 0,   0,  0,  0},
    '{100, 80, 100, 60, 0,  0},
    '{40,  20, 0,   0,  0,  0},
    '{80,  50, 80,  50, 80, 150},
    '{50,  20, 0,   0,  0,  0},
    '{20,  24, 16,  0,  0,  0},
    '{65,  28, 70,  34, 95, 28}
  };
  localparam int unsigned PatColor [8][3] = '{
    '{0,   0,   0},
    '{255, 140, 40},
    '{60,  255, 80},
    '{255, 180, 80},
    '{255, 0,   0},
    '{40,  120, 255},
    '{255, 255, 255},
    '{90,  255, 170}
  };

  typedef struct {
    lpps_pkg::kind_e kind;
    logic [2:0]      pattern;
    logic            dflt;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } cmd_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       running;
  } led_result_t;

  logic clk_i;
  logic rst_ni;

  lpps_in_if  in_if ();
  lpps_out_if out_if ();

  led_pulse_pattern_sequencer_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Behavioral state of the pattern player.
  logic        seq_active;
  int unsigned seq_step;
  int unsigned seq_len;
  int unsigned seq_pat;
  int unsigned seq_elapsed;
  int unsigned base_rgb [3];
  int unsigned led_rgb [3];

  // LED results still owed by the sequencer, oldest first.
  led_result_t expected_leds [$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  led_result_t want_led;
  cmd_t        taken_cmd;

  // 20 ns clock, low first so the first rising edge lands at 10 ns.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The receiver stalls at random with the probability of the current phase.
  // Ready starts low and is redrawn after every rising edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Shows the base color scaled by a step intensity, floored.
  function automatic void light(int unsigned level);
    for (int c = 0; c < 3; c++) begin
      led_rgb[c] = (base_rgb[c] * level) / 255;
    end
  endfunction

  // Stop, play of no pattern and the end of the last step all land here.
  // The base color is kept, only the LED goes dark.
  function automatic void go_dark();
    seq_active = 1'b0;
    seq_step   = 0;
    seq_len    = 0;
    for (int c = 0; c < 3; c++) begin
      led_rgb[c] = 0;
    end
  endfunction

  // Advances the model by one accepted command and returns the LED result
  // that the sequencer must produce for it.
  function automatic led_result_t predict_led(cmd_t c);
    led_result_t res;
    case (c.kind)
      lpps_pkg::KindTick: begin
        // Ticks while idle leave everything unchanged.
        if (seq_active) begin
          if (seq_elapsed < 255) seq_elapsed++;
          if (seq_elapsed >= SeqDur[seq_pat][seq_step]) begin
            seq_step++;
            if (seq_step >= seq_len) begin
              go_dark();
            end else begin
              seq_elapsed = 0;
              light(SeqLevel[seq_pat][seq_step]);
            end
          end
        end
      end
      lpps_pkg::KindPlay: begin
        if (c.pattern == lpps_pkg::PatNone) begin
          go_dark();
        end else begin
          // A play always restarts from step 0, even mid-pattern.
          base_rgb[0] = c.dflt ? PatColor[c.pattern][0] : c.red;
          base_rgb[1] = c.dflt ? PatColor[c.pattern][1] : c.green;
          base_rgb[2] = c.dflt ? PatColor[c.pattern][2] : c.blue;
          seq_pat     = c.pattern;
          seq_len     = SeqLen[c.pattern];
          seq_step    = 0;
          seq_elapsed = 0;
          seq_active  = (seq_len > 0);
          if (seq_active) light(SeqLevel[c.pattern][0]);
        end
      end
      lpps_pkg::KindStop: begin
        go_dark();
      end
      default: begin
        // A solid color ends the pattern but keeps the step index.
        seq_active  = 1'b0;
        seq_len     = 0;
        base_rgb[0] = c.red;
        base_rgb[1] = c.green;
        base_rgb[2] = c.blue;
        light(255);
      end
    endcase
    res.red     = led_rgb[0][7:0];
    res.green   = led_rgb[1][7:0];
    res.blue    = led_rgb[2][7:0];
    res.running = seq_active;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Scoreboard and watchdog. One process handles both channels so that the
  // order of prediction and checking never depends on the scheduler. The
  // result of a command can only leave on a later edge than its own
  // transfer, so the output side is checked before the input side predicts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        if (expected_leds.size() == 0) begin
          $display("%0t: result with no command pending, actual r=%0d g=%0d b=%0d run=%0b",
                   $realtime, out_if.led_red, out_if.led_green, out_if.led_blue,
                   out_if.running);
          fail_count++;
        end else begin
          want_led = expected_leds.pop_front();
          check_field("led_red",   want_led.red,   out_if.led_red);
          check_field("led_green", want_led.green, out_if.led_green);
          check_field("led_blue",  want_led.blue,  out_if.led_blue);
          check_field("running",   {7'd0, want_led.running}, {7'd0, out_if.running});
        end
      end
      if (in_if.valid && in_if.ready) begin
        quiet_cycles      = 0;
        taken_cmd.kind    = in_if.kind;
        taken_cmd.pattern = in_if.pattern;
        taken_cmd.dflt    = in_if.use_default_color;
        taken_cmd.red     = in_if.red_in;
        taken_cmd.green   = in_if.green_in;
        taken_cmd.blue    = in_if.blue_in;
        expected_leds.push_back(predict_led(taken_cmd));
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $realtime, WatchdogLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Presents one command and returns at the edge where it is transferred.
  // A random gap may come first; valid is only lowered when a gap is taken,
  // so back-to-back commands keep valid high across the boundary.
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.kind              <= c.kind;
    in_if.pattern           <= c.pattern;
    in_if.use_default_color <= c.dflt;
    in_if.red_in            <= c.red;
    in_if.green_in          <= c.green;
    in_if.blue_in           <= c.blue;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send(lpps_pkg::kind_e k, logic [2:0] p, logic d, logic [7:0] r,
                      logic [7:0] g, logic [7:0] b);
    cmd_t c;
    c.kind    = k;
    c.pattern = p;
    c.dflt    = d;
    c.red     = r;
    c.green   = g;
    c.blue    = b;
    send_cmd(c);
  endtask

  // Command of the given kind with every other field random. Fields that a
  // kind does not use must be ignored by the sequencer.
  function automatic cmd_t rand_fields(lpps_pkg::kind_e k);
    cmd_t c;
    c.kind    = k;
    c.pattern = $urandom_range(7);
    c.dflt    = $urandom_range(1);
    c.red     = $urandom_range(255);
    c.green   = $urandom_range(255);
    c.blue    = $urandom_range(255);
    return c;
  endfunction

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Commands with nothing playing: ticks, a stop and a play of no pattern
  // must all leave the LED dark and not start anything.
  task automatic test_idle_commands();
    send(lpps_pkg::KindTick, 3'd7, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindStop, 3'd7, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindPlay, lpps_pkg::PatNone, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindTick, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00);
  endtask

  // Solid colors at the extremes, and a tick afterwards that must not
  // touch the color since no pattern is playing.
  task automatic test_solid_colors();
    send(lpps_pkg::KindSolid, 3'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindSolid, 3'd7, 1'b1, 8'h00, 8'h00, 8'h00);
    send(lpps_pkg::KindSolid, 3'd5, 1'b1, 8'h55, 8'hAA, 8'h01);
    send(lpps_pkg::KindTick, 3'd2, 1'b1, 8'hAA, 8'h55, 8'hFE);
  endtask

  // Every pattern, alternating between the built-in color and a caller
  // color. Each play lands while the previous pattern is still running.
  task automatic test_every_pattern();
    for (int p = 1; p < 8; p++) begin
      send(lpps_pkg::KindPlay, p[2:0], p[0], 8'hFF, 8'h80, 8'h01);
    end
  endtask

  // Playback cut short by a restart, a stop, a play of no pattern and a
  // solid color, each while a pattern runs.
  task automatic test_interrupted_playback();
    send(lpps_pkg::KindPlay, 3'd4, 1'b1, 8'h00, 8'h00, 8'h00);
    send(lpps_pkg::KindPlay, 3'd2, 1'b0, 8'hFF, 8'h00, 8'hFF);
    send(lpps_pkg::KindStop, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    send(lpps_pkg::KindPlay, 3'd7, 1'b1, 8'h12, 8'h34, 8'h56);
    send(lpps_pkg::KindPlay, lpps_pkg::PatNone, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindPlay, 3'd1, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send(lpps_pkg::KindSolid, 3'd1, 1'b0, 8'h80, 8'h7F, 8'hC3);
    send(lpps_pkg::KindTick, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00);
  endtask

  // Random playback: mostly a play followed by a run of ticks, long enough
  // to reach the step boundaries and often the end of the shorter patterns.
  // About one sequence in eight is replaced by a single random command,
  // which covers stop, solid color and restarts mid-pattern.
  task automatic test_random_playback(int unsigned n_items);
    cmd_t        c;
    int unsigned sent;
    int unsigned run;
    int unsigned full;
    int unsigned i;
    logic [2:0]  pat;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        send_cmd(rand_fields(lpps_pkg::kind_e'($urandom_range(3))));
        sent++;
      end else begin
        // The shorter patterns are favored so that their end is reached.
        case ($urandom_range(9))
          0, 1:    pat = 3'd3;
          2, 3:    pat = 3'd5;
          4, 5:    pat = 3'd6;
          6:       pat = 3'd1;
          7:       pat = 3'd2;
          8:       pat = 3'd4;
          default: pat = 3'd7;
        endcase
        c         = rand_fields(lpps_pkg::KindPlay);
        c.pattern = pat;
        send_cmd(c);
        sent++;
        full = 0;
        for (i = 0; i < SeqLen[pat]; i++) full += SeqDur[pat][i];
        run = $urandom_range(full + 3);
        if (run > 110) run = $urandom_range(60, 110);
        for (i = 0; i < run && sent < n_items; i++) begin
          send_cmd(rand_fields(lpps_pkg::KindTick));
          sent++;
        end
      end
    end
  endtask

  initial begin
    // Every input gets a known value before the first edge.
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.kind              = lpps_pkg::KindTick;
    in_if.pattern           = lpps_pkg::PatNone;
    in_if.use_default_color = 1'b0;
    in_if.red_in            = 8'd0;
    in_if.green_in          = 8'd0;
    in_if.blue_in           = 8'd0;
    seq_active              = 1'b0;
    seq_step                = 0;
    seq_len                 = 0;
    seq_pat                 = 0;
    seq_elapsed             = 0;
    for (int c = 0; c < 3; c++) begin
      base_rgb[c] = 0;
      led_rgb[c]  = 0;
    end
    fail_count   = 0;
    quiet_cycles = 0;
    set_idling(0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_commands();
    test_solid_colors();
    test_every_pattern();
    test_interrupted_playback();

    set_idling(0, 0);
    test_random_playback(160);
    set_idling(80, 0);
    test_random_playback(160);
    set_idling(0, 80);
    test_random_playback(160);
    set_idling(25, 25);
    test_random_playback(160);

    // Drain: wait for every owed result, then keep clocking so that a
    // stray extra transfer would still be seen by the scoreboard.
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_leds.size() != 0);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/lpps_pkg.sv
design/lpps_in_if.sv
design/lpps_out_if.sv
design/led_pulse_pattern_sequencer_top.sv
verif/led_pulse_pattern_sequencer_top_tb.sv
